### hw/rtl/affp_pkg.sv
// Package for the atlas first-fit placer: field widths and size-arithmetic constants.
// No dependencies; used by the interfaces and the placer unit.
package affp_pkg;

  // Field widths of the request and result transfers
  localparam int unsigned SizeW = 11;
  localparam int unsigned IdW   = 5;
  localparam int unsigned PosW  = 10;

  // Width of sizes in cells, counters and sums of cell indexes
  localparam int unsigned CellW = 12;

  // Width of a pixel position before it is masked to PosW
  localparam int unsigned PixW  = 20;

endpackage

### hw/rtl/affp_if.sv
// Valid/ready channel interfaces for placement requests and results.
// Depends on affp_pkg for the field widths.
interface affp_req_if;
  logic                        valid;
  logic                        ready;
  logic [affp_pkg::SizeW-1:0]  image_width;
  logic [affp_pkg::SizeW-1:0]  image_height;
  logic [affp_pkg::IdW-1:0]    entry_id;

  modport source (output valid, image_width, image_height, entry_id, input ready);
  modport sink   (input valid, image_width, image_height, entry_id, output ready);
endinterface

interface affp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        placed;
  logic [affp_pkg::PosW-1:0]   x_position;
  logic [affp_pkg::PosW-1:0]   y_position;
  logic [affp_pkg::SizeW-1:0]  placed_width;
  logic [affp_pkg::SizeW-1:0]  placed_height;
  logic [affp_pkg::IdW-1:0]    slot_id;

  modport source (output valid, placed, x_position, y_position, placed_width,
                  placed_height, slot_id, input ready);
  modport sink   (input valid, placed, x_position, y_position, placed_width,
                  placed_height, slot_id, output ready);
endinterface

### hw/rtl/affp_map_mem.sv
// Cell occupancy memory: one row of cell bits per grid row, with a registered read.
// Per-row valid flops make unwritten rows read as all free after reset.
module affp_map_mem #(
  parameter int unsigned GRID_CELLS = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(GRID_CELLS)-1:0] addr_i,
  input  logic [GRID_CELLS-1:0]         wdata_i,
  output logic [GRID_CELLS-1:0]         rdata_o
);

  logic [GRID_CELLS-1:0] map_mem [GRID_CELLS];
  logic [GRID_CELLS-1:0] row_vld_q;
  logic [GRID_CELLS-1:0] rd_data_q;
  logic                  rd_vld_q;

  // Store and read rows
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      map_mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rd_data_q <= map_mem[addr_i];
    end
  end

  // Track written rows and the valid flag of the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[addr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

### hw/rtl/atlas_first_fit_placer_unit.sv
// First-fit atlas placer. One request at a time; the cell map lives in a one-port memory
// with a registered read. For each candidate row band it reads and ORs the band's rows,
// scans the merged band bit by bit for a free run of cw cells, then reads and writes back
// the claimed rows to mark them; entry and exit states frame each request. ch and cw are
// the size in cells plus spacing while below the grid size. Run time is set by the row-serial
// memory accesses and the column-serial free-run scan. A result waits in an output register.
module atlas_first_fit_placer_unit #(
  parameter int unsigned GRID_CELLS  = 128,
  parameter int unsigned CELL_PIXELS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  affp_req_if.sink  in_i,
  affp_rsp_if.source out_o
);

  localparam int unsigned RowW  = $clog2(GRID_CELLS);
  localparam int unsigned CellW = affp_pkg::CellW;

  typedef enum logic [2:0] {
    StIdle, StMrgRead, StMrgAcc, StScan, StMarkRead, StMarkWrite, StFinish
  } state_e;

  state_e                      state_q;
  logic [affp_pkg::SizeW-1:0]  w_q, h_q;
  logic [affp_pkg::IdW-1:0]    id_q;
  logic [CellW-1:0]            cw_q, ch_q, run_q;
  logic [RowW-1:0]             cy_q, k_q, x_q, cx_q;
  logic [GRID_CELLS-1:0]       merged_q;
  logic                        ok_q;
  logic                        out_vld_q, out_placed_q;
  logic [affp_pkg::PosW-1:0]   out_x_q, out_y_q;
  logic [affp_pkg::SizeW-1:0]  out_w_q, out_h_q;
  logic [affp_pkg::IdW-1:0]    out_id_q;

  logic [CellW-1:0]            cw_raw, ch_raw, cw_d, ch_d, run_inc;
  logic [RowW-1:0]             row_addr;
  logic [GRID_CELLS-1:0]       rdata, mark_mask;
  logic                        rd_en, wr_en, in_xfer;
  logic [affp_pkg::PixW-1:0]   px, py;

  // Round sizes up to cells and add spacing while below the grid size
  always_comb begin
    cw_raw = (CellW'(in_i.image_width) + CellW'(CELL_PIXELS - 1)) / CellW'(CELL_PIXELS);
    ch_raw = (CellW'(in_i.image_height) + CellW'(CELL_PIXELS - 1)) / CellW'(CELL_PIXELS);
    cw_d   = (cw_raw < CellW'(GRID_CELLS)) ? cw_raw + CellW'(1) : cw_raw;
    ch_d   = (ch_raw < CellW'(GRID_CELLS)) ? ch_raw + CellW'(1) : ch_raw;
  end

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign row_addr   = cy_q + k_q;
  assign rd_en      = (state_q == StMrgRead) || (state_q == StMarkRead);
  assign wr_en      = (state_q == StMarkWrite);
  assign run_inc    = run_q + CellW'(1);

  // Columns covered by the claimed rectangle
  always_comb begin
    for (int c = 0; c < GRID_CELLS; c++) begin
      mark_mask[c] = (CellW'(c) >= CellW'(cx_q)) && (CellW'(c) < CellW'(cx_q) + cw_q);
    end
  end

  affp_map_mem #(
    .GRID_CELLS(GRID_CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (rd_en),
    .wr_en_i (wr_en),
    .addr_i  (row_addr),
    .wdata_i (rdata | mark_mask),
    .rdata_o (rdata)
  );

  assign px = affp_pkg::PixW'(cx_q) * affp_pkg::PixW'(CELL_PIXELS);
  assign py = affp_pkg::PixW'(cy_q) * affp_pkg::PixW'(CELL_PIXELS);

  // Sequence merge, scan and mark; hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && out_o.ready && state_q != StFinish) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            w_q      <= in_i.image_width;
            h_q      <= in_i.image_height;
            id_q     <= in_i.entry_id;
            cw_q     <= cw_d;
            ch_q     <= ch_d;
            cy_q     <= '0;
            k_q      <= '0;
            merged_q <= '0;
            ok_q     <= 1'b0;
            if (cw_d > CellW'(GRID_CELLS) || ch_d > CellW'(GRID_CELLS)) begin
              state_q <= StFinish;
            end else begin
              state_q <= StMrgRead;
            end
          end
        end
        StMrgRead: state_q <= StMrgAcc;
        StMrgAcc: begin
          merged_q <= merged_q | rdata;
          if (CellW'(k_q) == ch_q - CellW'(1)) begin
            x_q     <= '0;
            run_q   <= '0;
            state_q <= StScan;
          end else begin
            k_q     <= k_q + RowW'(1);
            state_q <= StMrgRead;
          end
        end
        StScan: begin
          run_q <= merged_q[x_q] ? '0 : run_inc;
          if (!merged_q[x_q] && run_inc == cw_q) begin
            cx_q    <= RowW'(CellW'(x_q) + CellW'(1) - cw_q);
            k_q     <= '0;
            state_q <= StMarkRead;
          end else if (x_q == RowW'(GRID_CELLS - 1)) begin
            if (CellW'(cy_q) + CellW'(1) + ch_q <= CellW'(GRID_CELLS)) begin
              cy_q     <= cy_q + RowW'(1);
              k_q      <= '0;
              merged_q <= '0;
              state_q  <= StMrgRead;
            end else begin
              state_q <= StFinish;
            end
          end else begin
            x_q <= x_q + RowW'(1);
          end
        end
        StMarkRead: state_q <= StMarkWrite;
        StMarkWrite: begin
          if (CellW'(k_q) == ch_q - CellW'(1)) begin
            ok_q    <= 1'b1;
            state_q <= StFinish;
          end else begin
            k_q     <= k_q + RowW'(1);
            state_q <= StMarkRead;
          end
        end
        StFinish: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q    <= 1'b1;
            out_placed_q <= ok_q;
            out_x_q      <= ok_q ? px[affp_pkg::PosW-1:0] : '0;
            out_y_q      <= ok_q ? py[affp_pkg::PosW-1:0] : '0;
            out_w_q      <= ok_q ? w_q : '0;
            out_h_q      <= ok_q ? h_q : '0;
            out_id_q     <= id_q;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.placed        = out_placed_q;
  assign out_o.x_position    = out_x_q;
  assign out_o.y_position    = out_y_q;
  assign out_o.placed_width  = out_w_q;
  assign out_o.placed_height = out_h_q;
  assign out_o.slot_id       = out_id_q;

  // A failed placement reports no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.placed |-> out_o.x_position == '0 && out_o.y_position == '0)
    else $error("failed placement carries a position");

  // The row counter stays inside the rectangle height
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMrgAcc || state_q == StMarkWrite) |-> CellW'(k_q) < ch_q)
    else $error("row counter beyond rectangle height");

  // A row is written only right after it was read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(rd_en) && $past(row_addr) == row_addr)
    else $error("map write without matching read");

  // An accepted request closes the input until it completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("request accepted while busy");

endmodule
